FILE: rtl/core/rqd_pkg.sv
package rqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic [CNT_W-1:0]   entry_count;
        logic               head_valid;
        logic [ID_BITS-1:0] head_id;
    } res_t;

endpackage

FILE: rtl/core/rqd_ram.sv
module rqd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/rqd_seq.sv
module rqd_seq
    import rqd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic [ID_BITS-1:0] in_id,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [ID_BITS-1:0] ram_wdata,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [ID_BITS-1:0] ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [ID_BITS-1:0] head_reg, head_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [1:0]         status_reg, status_next;

    logic [ADDR_W-1:0]  idx_inc;
    logic [CNT_W-1:0]   idx_inc_cnt;
    logic [CNT_W-1:0]   idx_inc2_cnt;

    assign idx_inc      = idx_reg + ADDR_W'(1);
    assign idx_inc_cnt  = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_inc2_cnt = CNT_W'(idx_reg) + CNT_W'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        head_reg   <= head_next;
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_inc;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    status_next = STATUS_OK;
                    state_next  = S_RESP;
                    case (in_cmd)
                        CMD_APPEND: begin
                            if (occ_reg >= CNT_W'(QUEUE_DEPTH)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = occ_reg[ADDR_W-1:0];
                                ram_wdata = in_id;
                                if (occ_reg == '0) begin
                                    head_next = in_id;
                                end
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (occ_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else if (occ_reg == CNT_W'(1)) begin
                                occ_next = '0;
                            end else begin
                                // slide everything behind the head forward
                                ram_raddr  = ADDR_W'(1);
                                idx_next   = '0;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_DELETE: begin
                            if (occ_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                ram_raddr  = '0;
                                idx_next   = '0;
                                key_next   = in_id;
                                state_next = S_SEARCH;
                            end
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // read data belongs to slot idx_reg
                if (ram_rdata == key_reg) begin
                    status_next = STATUS_OK;
                    if (idx_inc_cnt >= occ_reg) begin
                        occ_next   = occ_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end else begin
                        ram_raddr  = idx_inc;
                        state_next = S_SHIFT;
                    end
                end else if (idx_inc_cnt >= occ_reg) begin
                    status_next = STATUS_NOTFOUND;
                    state_next  = S_RESP;
                end else begin
                    ram_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end
            S_SHIFT: begin
                // read data is slot idx_reg + 1, moves down into idx_reg
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_reg == '0) begin
                    head_next = ram_rdata;
                end
                if (idx_inc2_cnt < occ_reg) begin
                    ram_raddr = idx_reg + ADDR_W'(2);
                    idx_next  = idx_inc;
                end else begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status      = status_reg;
        res.entry_count = occ_reg;
        res.head_valid  = (occ_reg != '0);
        res.head_id     = (occ_reg != '0) ? head_reg : '0;
    end

endmodule

FILE: rtl/core/ready_queue_with_delete_by_id.sv
// Ready queue of up to 16 process ids kept in arrival order in a single-port-write,
// registered-read RAM. One command is taken at a time. Append, query and the
// error cases go from idle straight to the response state, and the result then
// passes through an output register onto m_tdata. Remove-head and remove-by-id walk
// the RAM one slot per cycle: the search reads one slot per cycle and the gap is
// closed by moving one slot per cycle behind the match before the response state.
// The result sits in an output register, so the next request is taken while a
// result still waits on m_tready.
module ready_queue_with_delete_by_id
    import rqd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[1:0], proc_id[9:2], zero[15:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // head_id[7:0], head_valid[8], entry_count[13:9],
                                   // status[15:14]
);

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ID_BITS-1:0] ram_rdata;

    logic               m_tvalid_reg, m_tvalid_next;
    res_t               m_res_reg, m_res_next;

    rqd_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[1:0]),
        .in_id     (s_tdata[2 +: ID_BITS]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    rqd_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.status, m_res_reg.entry_count,
                       m_res_reg.head_valid, 8'(m_res_reg.head_id)};

`ifndef SYNTHESIS
    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == (m_tdata[13:9] != '0))
                     && (m_tdata[13:9] <= CNT_W'(QUEUE_DEPTH)))
        else $error("head_valid disagrees with entry_count");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a command is in progress");

    a_no_accept_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && res_valid))
        else $error("sequencer idle and holding a result at once");
`endif

endmodule

FILE: test/ready_queue_checker.sv
module ready_queue_checker
    import rqd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // cmd[1:0], proc_id[9:2], zero[15:10]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // head_id[7:0], head_valid[8], entry_count[13:9],
                                   // status[15:14]
    output int          mismatch_count,
    output int          reports_checked,
    output int          reports_awaited,
    output int          peak_fill,
    output logic [3:0]  status_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ID_BITS-1:0] queue_slots [QUEUE_DEPTH];
    int                 fill_level;
    res_t               report_backlog [$];
    res_t               got_report;
    res_t               want_report;

    initial begin
        mismatch_count  = 0;
        reports_checked = 0;
        reports_awaited = 0;
        peak_fill       = 0;
        status_seen     = '0;
        fill_level      = 0;
    end

    // applies one command to the shadow queue and returns the report it should produce
    function automatic res_t run_queue_command(input logic [1:0] cmd,
                                               input logic [ID_BITS-1:0] id);
        res_t       rep;
        logic [1:0] st;
        int         hit;
        int         i;
        st  = STATUS_OK;
        hit = -1;
        case (cmd)
            CMD_APPEND: begin
                if (fill_level >= QUEUE_DEPTH) begin
                    st = STATUS_FULL;
                end else begin
                    queue_slots[fill_level] = id;
                    fill_level++;
                end
            end
            CMD_POP: begin
                if (fill_level == 0) st = STATUS_EMPTY;
                else hit = 0;
            end
            CMD_DELETE: begin
                if (fill_level == 0) begin
                    st = STATUS_EMPTY;
                end else begin
                    // scan from the tail so the match nearest the head wins
                    for (i = fill_level - 1; i >= 0; i--)
                        if (queue_slots[i] == id) hit = i;
                    if (hit < 0) st = STATUS_NOTFOUND;
                end
            end
            default: ; // query leaves the queue alone
        endcase
        if (hit >= 0) begin
            for (i = hit; i + 1 < fill_level; i++)
                queue_slots[i] = queue_slots[i + 1];
            fill_level--;
        end
        rep.head_id     = (fill_level > 0) ? queue_slots[0] : '0;
        rep.head_valid  = (fill_level > 0);
        rep.entry_count = CNT_W'(fill_level);
        rep.status      = st;
        return rep;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] queue report %0d: %s", $time, reports_checked, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                report_backlog.push_back(run_queue_command(s_tdata[1:0], s_tdata[9:2]));
                if (fill_level > peak_fill) peak_fill = fill_level;
            end
            if (m_tvalid && m_tready) begin
                got_report = res_t'(m_tdata);
                if (report_backlog.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report %h", m_tdata));
                end else begin
                    want_report = report_backlog.pop_front();
                    if (got_report.head_id !== want_report.head_id)
                        flag_mismatch($sformatf("head_id %h, want %h",
                                                got_report.head_id, want_report.head_id));
                    if (got_report.head_valid !== want_report.head_valid)
                        flag_mismatch($sformatf("head_valid %b, want %b",
                                                got_report.head_valid, want_report.head_valid));
                    if (got_report.entry_count !== want_report.entry_count)
                        flag_mismatch($sformatf("entry_count %0d, want %0d",
                                                got_report.entry_count,
                                                want_report.entry_count));
                    if (got_report.status !== want_report.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                got_report.status, want_report.status));
                    status_seen[want_report.status] = 1'b1;
                    reports_checked++;
                end
            end
            reports_awaited <= report_backlog.size();
        end
    end

endmodule

FILE: test/ready_queue_with_delete_by_id_test.sv
module ready_queue_with_delete_by_id_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rqd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_PER_PASS = 250;
    localparam int BIAS_BLOCK      = 60;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_off_req  = 1'b0;
    int          held_cycles   = 0;
    int          cycle_count   = 0;
    int          requests_sent = 0;

    int          mismatch_count;
    int          reports_checked;
    int          reports_awaited;
    int          peak_fill;
    logic [3:0]  status_seen;

    logic [ID_BITS-1:0] recent_ids [$];
    logic [ID_BITS-1:0] fill_ids [QUEUE_DEPTH] = '{
        8'h00, 8'hff, 8'h55, 8'haa, 8'h3c, 8'h55, 8'h80, 8'h01,
        8'h7f, 8'hc3, 8'h10, 8'h55, 8'h42, 8'hfe, 8'h08, 8'h99
    };

    ready_queue_with_delete_by_id u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ready_queue_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .reports_checked (reports_checked),
        .reports_awaited (reports_awaited),
        .peak_fill       (peak_fill),
        .status_seen     (status_seen)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ready_queue_with_delete_by_id_test NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_req && held_cycles < HOLD_OFF_CYCLES) begin
            m_tready    <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [ID_BITS-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, id, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // small ids give duplicates, extremes hit the edges of the field
    function automatic logic [ID_BITS-1:0] pick_id();
        case ($urandom_range(3))
            0: return ID_BITS'($urandom_range(7));
            1: return $urandom_range(1) ? '1 : '0;
            default: return ID_BITS'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_request(input bit filling);
        int                 roll;
        logic [1:0]         cmd;
        logic [ID_BITS-1:0] id;
        roll = $urandom_range(99);
        if (filling)
            cmd = (roll < 65) ? CMD_APPEND : (roll < 73) ? CMD_POP :
                  (roll < 90) ? CMD_DELETE : CMD_QUERY;
        else
            cmd = (roll < 10) ? CMD_APPEND : (roll < 55) ? CMD_POP :
                  (roll < 90) ? CMD_DELETE : CMD_QUERY;
        // deletes mostly name an id that was appended lately
        if (cmd == CMD_DELETE && recent_ids.size() > 0 && $urandom_range(3) != 0)
            id = recent_ids[$urandom_range(recent_ids.size() - 1)];
        else
            id = pick_id();
        if (cmd == CMD_APPEND) begin
            recent_ids.push_back(id);
            if (recent_ids.size() > 24) void'(recent_ids.pop_front());
        end
        send_request(cmd, id);
    endtask

    initial begin
        int pass_idx;
        int i;
        repeat (6) @(posedge aclk);
        aresetn       <= 1'b1;
        send_idle_pct <= 29;
        recv_idle_pct <= 67;
        @(posedge aclk);

        // empty queue corner cases
        send_request(CMD_QUERY, 8'hff);
        send_request(CMD_POP, 8'h5a);
        send_request(CMD_DELETE, 8'h00);
        // delete by id on a single entry must empty the queue
        send_request(CMD_APPEND, 8'h5a);
        send_request(CMD_DELETE, 8'h5a);
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(CMD_APPEND, fill_ids[i]);
        send_request(CMD_APPEND, 8'h12);
        send_request(CMD_DELETE, 8'h77);
        send_request(CMD_DELETE, 8'h55);
        send_request(CMD_DELETE, 8'h99);
        send_request(CMD_DELETE, 8'h00);
        send_request(CMD_POP, 8'hff);
        send_request(CMD_QUERY, 8'h00);

        for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
            if (pass_idx == 1) begin
                send_idle_pct <= 67;
                recv_idle_pct <= 29;
            end else if (pass_idx == 2) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                hold_off_req  <= 1'b1;
            end
            for (i = 0; i < RANDOM_PER_PASS; i++)
                send_random_request(((i / BIAS_BLOCK) % 2) == 0);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (reports_awaited != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d commands, checked %0d queue reports, peak occupancy %0d",
                 requests_sent, reports_checked, peak_fill);
        $display("status codes seen (notfound/full/empty/ok bits): %b, %s %0d cycles",
                 status_seen, "long output stall", held_cycles);
        if (mismatch_count == 0) begin
            $display("ready_queue_with_delete_by_id_test OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("ready_queue_with_delete_by_id_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rqd_pkg.sv
rtl/core/rqd_ram.sv
rtl/core/rqd_seq.sv
rtl/core/ready_queue_with_delete_by_id.sv
test/ready_queue_checker.sv
test/ready_queue_with_delete_by_id_test.sv
